@@ rtl/core/sobel_pkg.sv @@
// shared types and constants for the sobel edge magnitude block
package sobel_pkg;

   localparam int CHANNELS = 3;
   localparam int PIX_W = 24;
   localparam int GRAD_W = 11;
   localparam int SUM_W = 21;
   localparam int ROOT_STEPS = 8;
   localparam logic [SUM_W-1:0] SQRT_SAT = 21'd65281;
   localparam logic [7:0] MAX_EDGE = 8'd255;
   localparam logic [10:0] WIDTH_RESET = 11'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;
   localparam logic KIND_PIXEL = 1'b0;

   typedef enum logic {
      REG_WIDTH = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_GRAD,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic accept;
      logic shift;
      logic grad;
      logic square;
      logic sum;
      logic root_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic root_last;
      logic emit;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/sobel_ctrl.sv @@
// controller state machine sequencing one request through the datapath
module sobel_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sobel_pkg::status_type status,
   output sobel_pkg::cmd_type    cmd
);
   import sobel_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SHIFT;
         end
         ST_SHIFT:  state_in = ST_GRAD;
         ST_GRAD:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_last) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (!status.emit || status.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SHIFT:  cmd.shift = 1'b1;
         ST_GRAD:   cmd.grad = 1'b1;
         ST_SQUARE: cmd.square = 1'b1;
         ST_SUM:    cmd.sum = 1'b1;
         ST_ROOT:   cmd.root_step = 1'b1;
         ST_FINAL:  cmd.load = status.emit && status.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

@@ rtl/core/sobel_dp.sv @@
// datapath: line stores, window, position counters, gradients and square root lanes
module sobel_dp #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sobel_pkg::cmd_type    cmd,
   output sobel_pkg::status_type status,
   input  logic [10:0]          cfg_width,
   input  logic [12:0]          cfg_height,
   input  logic                 req_kind,
   input  logic [7:0]           req_pixel_red,
   input  logic [7:0]           req_pixel_green,
   input  logic [7:0]           req_pixel_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_edge_red,
   output logic [7:0]           rsp_edge_green,
   output logic [7:0]           rsp_edge_blue,
   output logic                 rsp_frame_end
);
   import sobel_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CW1 = COL_W + 1;
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

   logic [PIX_W-1:0] mem_a [MAX_WIDTH];
   logic [PIX_W-1:0] mem_b [MAX_WIDTH];
   logic [PIX_W-1:0] mid_rd_ff;
   logic [PIX_W-1:0] top_rd_ff;
   logic [PIX_W-1:0] s_ff;
   logic [PIX_W-1:0] win_ff [3][3];
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             zl_ff, zr_ff, emit_ff, last_ff;
   logic signed [GRAD_W-1:0] gx_ff [CHANNELS];
   logic signed [GRAD_W-1:0] gy_ff [CHANNELS];
   logic [SUM_W-1:0] sqx_ff [CHANNELS];
   logic [SUM_W-1:0] sqy_ff [CHANNELS];
   logic [SUM_W-1:0] sum_ff [CHANNELS];
   logic [7:0]       k_ff [CHANNELS];
   logic [15:0]      ksq_ff [CHANNELS];
   logic [2:0]       idx_ff;
   logic             rsp_valid_ff;
   logic [7:0]       edge_ff [CHANNELS];
   logic             frame_end_ff;

   logic [CW1-1:0]   w_eff;
   logic [ROW_W-1:0] h_eff, h1;
   logic [CW1-1:0]   c_next;
   logic [PIX_W-1:0] top, mid;
   logic             emit_in, last_in;
   logic [7:0]       res_in [CHANNELS];
   logic signed [GRAD_W-1:0] gx_in [CHANNELS];
   logic signed [GRAD_W-1:0] gy_in [CHANNELS];

   always_comb begin
      if (cfg_width == 11'd0) w_eff = CW1'(1);
      else if ({21'd0, cfg_width} > 32'(MAX_WIDTH)) w_eff = CW1'(MAX_WIDTH);
      else w_eff = CW1'(cfg_width);
      if (cfg_height == 13'd0) h_eff = ROW_W'(1);
      else if ({19'd0, cfg_height} > 32'(MAX_HEIGHT)) h_eff = ROW_W'(MAX_HEIGHT);
      else h_eff = ROW_W'(cfg_height);
      h1 = h_eff + ROW_W'(1);
      c_next = {1'b0, col_ff} + CW1'(1);
      top = (row_ff >= ROW_W'(2)) ? top_rd_ff : '0;
      mid = (row_ff >= ROW_W'(1)) ? mid_rd_ff : '0;
      last_in = (row_ff == h1) && (col_ff == '0);
      emit_in = ((row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && (col_ff != '0)))
                && ((row_ff < h1) || last_in);
   end

   // line stores
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mid_rd_ff <= mem_a[col_ff];
         top_rd_ff <= mem_b[col_ff];
      end
      if (cmd.shift) begin
         mem_a[col_ff] <= s_ff;
         mem_b[col_ff] <= mid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (req_kind == KIND_PIXEL && row_ff < h_eff)
            s_ff <= {req_pixel_red, req_pixel_green, req_pixel_blue};
         else
            s_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               win_ff[i][j] <= '0;
      end else if (cmd.shift) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2][0] <= top;
         win_ff[2][1] <= mid;
         win_ff[2][2] <= s_ff;
         if (row_ff >= h1) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (c_next >= w_eff) begin
            col_ff <= '0;
            row_ff <= row_ff + ROW_W'(1);
         end else begin
            col_ff <= c_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         zr_ff <= (col_ff == '0);
         zl_ff <= ((col_ff == '0) && (w_eff == CW1'(1))) || (col_ff == COL_W'(1));
         emit_ff <= emit_in;
         last_ff <= last_in;
      end
   end

   // gradients per channel
   always_comb begin
      logic signed [GRAD_W-1:0] p [3][3];
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               p[i][j] = $signed({3'b000, win_ff[i][j][8*(2-ch) +: 8]});
               if ((i == 0 && zl_ff) || (i == 2 && zr_ff)) p[i][j] = '0;
            end
         gx_in[ch] = p[2][0] + (p[2][1] <<< 1) + p[2][2]
                   - p[0][0] - (p[0][1] <<< 1) - p[0][2];
         gy_in[ch] = p[0][2] + (p[1][2] <<< 1) + p[2][2]
                   - p[0][0] - (p[1][0] <<< 1) - p[2][0];
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (cmd.grad) begin
            gx_ff[ch] <= gx_in[ch];
            gy_ff[ch] <= gy_in[ch];
         end
         if (cmd.square) begin
            sqx_ff[ch] <= SUM_W'($unsigned(SUM_W'(gx_ff[ch]) * SUM_W'(gx_ff[ch])));
            sqy_ff[ch] <= SUM_W'($unsigned(SUM_W'(gy_ff[ch]) * SUM_W'(gy_ff[ch])));
         end
         if (cmd.sum) begin
            sum_ff[ch] <= sqx_ff[ch] + sqy_ff[ch];
         end
      end
   end

   // bitwise square root lanes
   always_ff @(posedge clock) begin
      logic [7:0]  trial;
      logic [15:0] tsq;
      if (cmd.sum) begin
         idx_ff <= 3'(ROOT_STEPS - 1);
         for (int ch = 0; ch < CHANNELS; ch++) begin
            k_ff[ch] <= '0;
            ksq_ff[ch] <= '0;
         end
      end else if (cmd.root_step) begin
         idx_ff <= idx_ff - 3'd1;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            trial = k_ff[ch] | (8'd1 << idx_ff);
            tsq = trial * trial;
            if (tsq <= sum_ff[ch][15:0]) begin
               k_ff[ch] <= trial;
               ksq_ff[ch] <= tsq;
            end
         end
      end
   end

   always_comb begin
      logic [15:0] rem;
      logic [8:0]  kr;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         rem = sum_ff[ch][15:0] - ksq_ff[ch];
         kr = (rem > {8'd0, k_ff[ch]}) ? {1'b0, k_ff[ch]} + 9'd1 : {1'b0, k_ff[ch]};
         if (sum_ff[ch] >= SQRT_SAT || kr > {1'b0, MAX_EDGE}) res_in[ch] = MAX_EDGE;
         else res_in[ch] = kr[7:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int ch = 0; ch < CHANNELS; ch++) edge_ff[ch] <= res_in[ch];
         frame_end_ff <= last_ff;
      end
   end

   assign status.root_last = (idx_ff == 3'd0);
   assign status.emit = emit_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_edge_red = edge_ff[0];
   assign rsp_edge_green = edge_ff[1];
   assign rsp_edge_blue = edge_ff[2];
   assign rsp_frame_end = frame_end_ff;

endmodule

@@ rtl/core/sobel_edge_magnitude_rgb_top.sv @@
// top level of the rgb sobel edge magnitude block with its register port
//
// pixels enter in raster order on the req_ channel (valid/stall), one request
// per pixel; after a frame of width*height pixels, width+1 pad requests
// (req_kind high) flush the remaining results. each request yields zero or
// one result on the rsp_ channel: the clamped rounded gradient magnitude of
// red, green and blue for the pixel width+1 places earlier, with
// rsp_frame_end high on the last pixel of the frame.
// one request passes in turn through a line store read, the window shift, the
// gradient, square and sum steps, an 8-step bitwise square root run in
// parallel in the three channel lanes and the output load.
// frame_width (address 0) and frame_height (address 4) are to be written
// through the register port only while the block is idle; the block itself
// does not enforce this. reset clears the position, the window and the result
// register and sets the size to 640 by 480. a stalled result stays in the
// output register; the next request is still accepted and holds only at its
// final step until the output register is free.
module sobel_edge_magnitude_rgb_top #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_pixel_red,
   input  logic [7:0]  req_pixel_green,
   input  logic [7:0]  req_pixel_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_edge_red,
   output logic [7:0]  rsp_edge_green,
   output logic [7:0]  rsp_edge_blue,
   output logic        rsp_frame_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sobel_pkg::*;

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   reg_index_type sel;
   cmd_type cmd;
   status_type status;

   assign sel = reg_index_type'(paddr[2]);
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (psel && penable && pwrite) begin
         case (sel)
            REG_WIDTH:  width_ff <= pwdata[10:0];
            REG_HEIGHT: height_ff <= pwdata[12:0];
            default:    width_ff <= width_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_WIDTH:  prdata = {21'd0, width_ff};
         REG_HEIGHT: prdata = {19'd0, height_ff};
         default:    prdata = '0;
      endcase
   end

   sobel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sobel_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg_width       (width_ff),
      .cfg_height      (height_ff),
      .req_kind        (req_kind),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_edge_red    (rsp_edge_red),
      .rsp_edge_green  (rsp_edge_green),
      .rsp_edge_blue   (rsp_edge_blue),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

@@ tb/sv/sobel_edge_magnitude_rgb_top_test.sv @@
// self-checking testbench for the rgb sobel edge magnitude block
module sobel_edge_magnitude_rgb_top_test;
   import sobel_pkg::*;

   localparam int LINE_MAX = 1024;
   localparam int ROWS_MAX = 4096;
   localparam int DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT = 1500000;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } edge_result_type;

   class edge_scoreboard;
      logic [23:0] line_mem[2*LINE_MAX];
      logic [23:0] win[3][3];
      int unsigned col;
      int unsigned row;
      logic [10:0] width_reg;
      logic [12:0] height_reg;
      edge_result_type expected_edges[$];
      int errors;

      function new();
         foreach (line_mem[i]) line_mem[i] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         col = 0;
         row = 0;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         errors = 0;
      endfunction

      function logic [7:0] root_round(int unsigned x);
         int unsigned k;
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         if (x >= 65281) return MAX_EDGE;
         lo = 0;
         hi = 256;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= x) lo = mid;
            else hi = mid;
         end
         k = lo;
         if (x > k * k + k) k++;
         return (k > 255) ? MAX_EDGE : k[7:0];
      endfunction

      function logic [7:0] magnitude(logic [23:0] v[3][3], int sh);
         int p[3][3];
         int gx;
         int gy;
         foreach (p[i, j]) p[i][j] = int'((v[i][j] >> sh) & 24'hff);
         gx = -p[0][0] - 2 * p[0][1] - p[0][2] + p[2][0] + 2 * p[2][1] + p[2][2];
         gy = -p[0][0] - 2 * p[1][0] - p[2][0] + p[0][2] + 2 * p[1][2] + p[2][2];
         return root_round(int'(gx * gx + gy * gy));
      endfunction

      function void note_request(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int unsigned w;
         int unsigned h;
         int unsigned c;
         int unsigned rr;
         logic [23:0] s;
         logic [23:0] top;
         logic [23:0] midv;
         logic [23:0] view[3][3];
         logic emit;
         logic last;
         edge_result_type res;
         w = width_reg;
         h = height_reg;
         if (w == 0) w = 1;
         if (w > LINE_MAX) w = LINE_MAX;
         if (h == 0) h = 1;
         if (h > ROWS_MAX) h = ROWS_MAX;
         rr = row;
         c = col % LINE_MAX;
         s = (kind == KIND_PIXEL && rr < h) ? {r, g, b} : 24'h0;
         top = (rr >= 2) ? line_mem[LINE_MAX + c] : 24'h0;
         midv = (rr >= 1) ? line_mem[c] : 24'h0;
         line_mem[LINE_MAX + c] = midv;
         line_mem[c] = s;
         for (int j = 0; j < 3; j++) begin
            win[0][j] = win[1][j];
            win[1][j] = win[2][j];
         end
         win[2][0] = top;
         win[2][1] = midv;
         win[2][2] = s;
         view = win;
         if (c == 0) begin
            for (int j = 0; j < 3; j++) view[2][j] = '0;
            if (w == 1) for (int j = 0; j < 3; j++) view[0][j] = '0;
         end else if (c == 1) begin
            for (int j = 0; j < 3; j++) view[0][j] = '0;
         end
         last = (rr == h + 1 && c == 0);
         emit = (rr >= 2 || (rr == 1 && c >= 1)) && (rr < h + 1 || last);
         if (rr >= h + 1) begin
            col = 0;
            row = 0;
         end else if (c + 1 >= w) begin
            col = 0;
            row = rr + 1;
         end else begin
            col = c + 1;
         end
         if (emit) begin
            res.red = magnitude(view, 16);
            res.green = magnitude(view, 8);
            res.blue = magnitude(view, 0);
            res.frame_end = last;
            expected_edges.push_back(res);
         end
      endfunction

      function void check_result(edge_result_type got);
         edge_result_type exp_res;
         if (expected_edges.size() == 0) begin
            $display("%0t: unexpected result r=%0d g=%0d b=%0d end=%0b", $time,
                     got.red, got.green, got.blue, got.frame_end);
            errors++;
            return;
         end
         exp_res = expected_edges.pop_front();
         if (got.red !== exp_res.red)
            $display("%0t: edge_red expected %0d actual %0d", $time, exp_res.red, got.red);
         if (got.green !== exp_res.green)
            $display("%0t: edge_green expected %0d actual %0d", $time,
                     exp_res.green, got.green);
         if (got.blue !== exp_res.blue)
            $display("%0t: edge_blue expected %0d actual %0d", $time, exp_res.blue, got.blue);
         if (got.frame_end !== exp_res.frame_end)
            $display("%0t: frame_end expected %0b actual %0b", $time,
                     exp_res.frame_end, got.frame_end);
         if (got.red !== exp_res.red || got.green !== exp_res.green ||
             got.blue !== exp_res.blue || got.frame_end !== exp_res.frame_end)
            errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_pixel_red;
   logic [7:0]  req_pixel_green;
   logic [7:0]  req_pixel_blue;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_edge_red;
   logic [7:0]  rsp_edge_green;
   logic [7:0]  rsp_edge_blue;
   logic        rsp_frame_end;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   edge_scoreboard sb;
   bit quiet;
   int stall_left;
   longint cycles;
   int random_items;

   sobel_edge_magnitude_rgb_top u_top (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: check accepted results and stall in random bursts
   always @(posedge clock) begin
      edge_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.red = rsp_edge_red;
         got.green = rsp_edge_green;
         got.blue = rsp_edge_blue;
         got.frame_end = rsp_frame_end;
         sb.check_result(got);
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(1, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(int'(idx) * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.width_reg = (idx == REG_WIDTH) ? value[10:0] : sb.width_reg;
      sb.height_reg = (idx == REG_HEIGHT) ? value[12:0] : sb.height_reg;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_request(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                               bit calm);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pixel_red <= r;
      req_pixel_green <= g;
      req_pixel_blue <= b;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, r, g, b);
      if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] sample_value(int mode);
      if (mode == 1) return $urandom_range(0, 1) ? 8'hff : 8'h00;
      if (mode == 3) return 8'hff;
      return 8'($urandom);
   endfunction

   // mode 0 random, 1 each channel 0 or 255, 2 with misplaced kinds, 3 all white
   task automatic run_frame(logic [10:0] wreg, logic [12:0] hreg, int mode);
      int unsigned w;
      int unsigned h;
      bit calm;
      logic kind;
      wait_drained();
      csr_write(REG_WIDTH, 32'(wreg));
      csr_write(REG_HEIGHT, 32'(hreg));
      w = (wreg == 0) ? 1 : (wreg > LINE_MAX ? LINE_MAX : wreg);
      h = (hreg == 0) ? 1 : (hreg > ROWS_MAX ? ROWS_MAX : hreg);
      calm = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < w * h; i++) begin
         kind = (mode == 2 && $urandom_range(0, 5) == 0) ? 1'b1 : KIND_PIXEL;
         send_request(kind, sample_value(mode), sample_value(mode), sample_value(mode), calm);
      end
      for (int unsigned i = 0; i <= w; i++) begin
         kind = (mode == 2 && $urandom_range(0, 2) == 0) ? KIND_PIXEL : 1'b1;
         send_request(kind, 8'($urandom), 8'($urandom), 8'($urandom), calm);
      end
      random_items += w * h + w + 1;
   endtask

   initial begin
      int wr;
      sb = new();
      quiet = 1'b0;
      stall_left = 0;
      cycles = 0;
      random_items = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_pixel_red = '0;
      req_pixel_green = '0;
      req_pixel_blue = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_frame(11'd1, 13'd1, 0);
      run_frame(11'd0, 13'd0, 0);
      run_frame(11'd3, 13'd3, 1);
      run_frame(11'd5, 13'd2, 3);
      run_frame(11'd4, 13'd3, 2);
      run_frame(11'd9, 13'd6, 0);
      run_frame(11'd1, 13'd12, 1);
      run_frame(11'd2, 13'd1, 2);

      random_items = 0;
      while (random_items < 960) begin
         if (random_items > 820) quiet = 1'b1;
         wr = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
         run_frame(11'(wr), 13'($urandom_range(1, 8)), $urandom_range(0, 2));
      end
      wait_drained();
      if (sb.errors == 0 && sb.expected_edges.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sobel_edge_magnitude_rgb_top.f @@
rtl/core/sobel_pkg.sv
rtl/core/sobel_ctrl.sv
rtl/core/sobel_dp.sv
rtl/core/sobel_edge_magnitude_rgb_top.sv
tb/sv/sobel_edge_magnitude_rgb_top_test.sv
